[src/wsd_pkg.sv]
package wsd_pkg;

  localparam int unsigned PenaltyWidth = 40;
  localparam int unsigned WeightWidth  = 16;
  localparam int unsigned WeightFrac   = 14;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [WeightWidth-1:0]  WeightOne    = 16'd16384;
  localparam logic [WeightWidth-1:0]  FalloffReset = 16'd14746;
  localparam logic [PenaltyWidth-1:0] VetoReset    = 40'd524288000;
  localparam logic [PenaltyWidth-1:0] MatchReset   = 40'd21845333;

  typedef enum logic [1:0] {
    VERDICT_VETO  = 2'd0,
    VERDICT_DOUBT = 2'd1,
    VERDICT_MATCH = 2'd2
  } verdict_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_FALLOFF = 2'd0,
    CFG_VETO    = 2'd1,
    CFG_MATCH   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic       last;
  } in_t;

  typedef struct packed {
    verdict_e                 verdict;
    logic [PenaltyWidth-1:0]  penalty_sum;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic mul;
    logic acc;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic item_last;
    logic out_busy;
  } status_t;

endpackage

[src/wsd_ctrl.sv]
module wsd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  wsd_pkg::status_t status_i,
  output wsd_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ACC  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (status_i.item_last) begin
          state_d = ST_FIN;
        end else begin
          // The next transaction can be taken while this one accumulates.
          in_stall_o = 1'b0;
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_MUL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_goes_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_MUL)
    else $error("accepted transaction did not start the multiply step");
  a_fin_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC && status_i.item_last |=> state_q == ST_FIN)
    else $error("last transaction did not lead to the finish step");
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");
`endif

endmodule

[src/wsd_dp.sv]
module wsd_dp #(
  parameter int unsigned SIG_LEN = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  wsd_pkg::in_t                           in_data_i,
  input  wsd_pkg::cmd_t                          cmd_i,
  output wsd_pkg::status_t                       status_o,
  input  logic                                   cfg_we_i,
  input  logic [wsd_pkg::CfgIndexWidth-1:0]      cfg_index_i,
  input  logic [wsd_pkg::PenaltyWidth-1:0]       cfg_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output wsd_pkg::out_t                          out_data_o
);

  localparam int unsigned IdxWidth = $clog2(SIG_LEN + 1);
  localparam int unsigned PW = wsd_pkg::PenaltyWidth;
  localparam int unsigned WW = wsd_pkg::WeightWidth;

  logic [WW-1:0]       falloff_q;
  logic [PW-1:0]       veto_q;
  logic [PW-1:0]       match_q;

  wsd_pkg::in_t        in_q;
  logic [15:0]         dsq_q, dsq_d;
  logic [2*WW-1:0]     wprod_q, wprod_d;
  logic                active_q, active_d;
  logic                upd_q, upd_d;

  logic [IdxWidth-1:0] idx_q;
  logic [WW-1:0]       weight_q, weight_d;
  logic [PW-1:0]       acc_q, acc_d;

  wsd_pkg::out_t       out_q, out_d;
  logic                out_valid_q;

  logic [7:0]          diff;
  logic [2*WW-1:0]     term;
  logic [PW:0]         sum;
  logic [2*WW:0]       wround;
  logic [2*WW-wsd_pkg::WeightFrac:0] wshift;
  wsd_pkg::verdict_e   verdict;

  // Multiply step: squared difference and the candidate next weight.
  always_comb begin
    diff     = (in_q.byte_a >= in_q.byte_b) ? (in_q.byte_a - in_q.byte_b)
                                            : (in_q.byte_b - in_q.byte_a);
    dsq_d    = {8'b0, diff} * {8'b0, diff};
    wprod_d  = {{WW{1'b0}}, weight_q} * {{WW{1'b0}}, falloff_q};
    active_d = (idx_q != '0) && (idx_q < IdxWidth'(SIG_LEN));
    // The weight moves on after each index of the form 2^k - 1.
    upd_d    = active_d && ((idx_q & (idx_q + IdxWidth'(1))) == '0);
  end

  // Accumulate step.
  always_comb begin
    term   = {{(2*WW-16){1'b0}}, dsq_q} * {{WW{1'b0}}, weight_q};
    sum    = {1'b0, acc_q} + {{(PW+1-2*WW){1'b0}}, term};
    acc_d  = sum[PW] ? {PW{1'b1}} : sum[PW-1:0];
    wround = {1'b0, wprod_q} + (2*WW+1)'(1 << (wsd_pkg::WeightFrac - 1));
    wshift = wround[2*WW:wsd_pkg::WeightFrac];
    weight_d = (|wshift[2*WW-wsd_pkg::WeightFrac:WW]) ? {WW{1'b1}} : wshift[WW-1:0];
  end

  // Veto is tested first, so it wins when both limits hold.
  always_comb begin
    if (acc_q >= veto_q) begin
      verdict = wsd_pkg::VERDICT_VETO;
    end else if (acc_q <= match_q) begin
      verdict = wsd_pkg::VERDICT_MATCH;
    end else begin
      verdict = wsd_pkg::VERDICT_DOUBT;
    end
    out_d.verdict     = verdict;
    out_d.penalty_sum = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      falloff_q <= wsd_pkg::FalloffReset;
      veto_q    <= wsd_pkg::VetoReset;
      match_q   <= wsd_pkg::MatchReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == wsd_pkg::CFG_FALLOFF) begin
        falloff_q <= cfg_data_i[WW-1:0];
      end else if (cfg_index_i == wsd_pkg::CFG_VETO) begin
        veto_q <= cfg_data_i;
      end else if (cfg_index_i == wsd_pkg::CFG_MATCH) begin
        match_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.mul) begin
      dsq_q   <= dsq_d;
      wprod_q <= wprod_d;
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      upd_q       <= 1'b0;
      idx_q       <= '0;
      weight_q    <= wsd_pkg::WeightOne;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.mul) begin
        active_q <= active_d;
        upd_q    <= upd_d;
      end
      if (cmd_i.acc) begin
        if (active_q) begin
          acc_q <= acc_d;
        end
        if (upd_q) begin
          weight_q <= weight_d;
        end
        if (idx_q < IdxWidth'(SIG_LEN)) begin
          idx_q <= idx_q + IdxWidth'(1);
        end
      end
      if (cmd_i.finish) begin
        idx_q    <= '0;
        weight_q <= wsd_pkg::WeightOne;
        acc_q    <= '0;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.item_last = in_q.last;
  assign status_o.out_busy  = out_valid_q && out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

`ifndef SYNTHESIS
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> acc_q == '0 && idx_q == '0 && weight_q == wsd_pkg::WeightOne)
    else $error("stream state not cleared after the last transaction");
  a_result_is_penalty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_q.penalty_sum == $past(acc_q))
    else $error("reported penalty differs from the accumulator");
  a_acc_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.finish |=> acc_q >= $past(acc_q))
    else $error("penalty decreased within a signature");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(out_valid_q && out_stall_i))
    else $error("pending result overwritten");
`endif

endmodule

[src/weighted_signature_distance.sv]
// Weighted squared distance between two byte signatures. One transaction
// carries one byte pair; a transaction with last set closes the signature
// and yields one result (verdict and final Q.14 penalty), all others yield
// none. The pair at index 0 and any pair at index SIG_LEN or beyond add
// nothing. Each transaction passes two steps: the multiply step forms the
// squared difference and the next weight product, and the accumulate step
// multiplies the term by the weight and accumulates. A closing transaction
// then takes a finish step to compare against the limits and load the output
// register, and waits there while an earlier result is still held by a
// stalled receiver. Write the configuration registers only while the block is idle.
module weighted_signature_distance #(
  parameter int unsigned SIG_LEN = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  wsd_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output wsd_pkg::out_t                       out_data_o,
  input  logic                                cfg_we_i,
  input  logic [wsd_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [wsd_pkg::PenaltyWidth-1:0]    cfg_data_i
);

  wsd_pkg::cmd_t    cmd;
  wsd_pkg::status_t status;

  wsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wsd_dp #(
    .SIG_LEN (SIG_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
